[sv/mvma_pkg.sv]
`timescale 1ns / 1ps

package mvma_pkg;

  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 8;
  localparam int CNT_W       = 9;
  localparam int STORE_DEPTH = 256;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;

  typedef enum logic [1:0] {
    CMD_LOAD_VEC  = 2'd0,
    CMD_LOAD_INIT = 2'd1,
    CMD_MATRIX    = 2'd2
  } cmd_e;

  // register index is byte address bit 2
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // one matrix element handed from front to back
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] vec;
    logic [DATA_W-1:0] init;
    logic              first_col;
    logic              last_col;
    logic [ADDR_W-1:0] row;
    logic              last_row;
  } elem_t;

  // zero counts as one, saturate at the store depth
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r);
    logic [CNT_W-1:0] n;
    n = r;
    if (r == '0) begin
      n = CNT_W'(1);
    end else if (r > CNT_W'(STORE_DEPTH)) begin
      n = CNT_W'(STORE_DEPTH);
    end
    return n;
  endfunction

endpackage

[sv/mvma_ram.sv]
`timescale 1ns / 1ps

module mvma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/mvma_front.sv]
`timescale 1ns / 1ps

module mvma_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [mvma_pkg::ADDR_W-1:0]         index_i,
  input  logic [mvma_pkg::DATA_W-1:0]         value_i,
  input  logic [mvma_pkg::CNT_W-1:0]          rows_i,
  input  logic [mvma_pkg::CNT_W-1:0]          cols_i,
  input  logic [mvma_pkg::FIFO_CNT_W-1:0]     fifo_count_i,
  output logic                                push_o,
  output mvma_pkg::elem_t                     elem_o
);

  logic                          accept;
  mvma_pkg::cmd_e                cmd;
  logic                          vec_we;
  logic                          init_we;
  logic                          mat_go;
  logic [mvma_pkg::DATA_W-1:0]   vec_rdata;
  logic [mvma_pkg::DATA_W-1:0]   init_rdata;
  logic                          last_col;
  logic                          last_row;

  logic [mvma_pkg::ADDR_W-1:0]   col_q, col_d;
  logic [mvma_pkg::ADDR_W-1:0]   row_q, row_d;
  logic [mvma_pkg::STORE_DEPTH-1:0] init_vld_q;

  logic                          s1_vld_q;
  logic [mvma_pkg::DATA_W-1:0]   s1_value_q;
  logic                          s1_first_q;
  logic                          s1_last_col_q;
  logic [mvma_pkg::ADDR_W-1:0]   s1_row_q;
  logic                          s1_last_row_q;
  logic                          s1_init_ok_q;

  // leave room in the queue for the item now in the read stage
  assign in_stall_o = (fifo_count_i + mvma_pkg::FIFO_CNT_W'(s1_vld_q))
                      >= mvma_pkg::FIFO_CNT_W'(mvma_pkg::FIFO_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd        = mvma_pkg::cmd_e'(command_i);

  always_comb begin
    vec_we  = 1'b0;
    init_we = 1'b0;
    mat_go  = 1'b0;
    if (accept) begin
      case (cmd)
        mvma_pkg::CMD_LOAD_VEC:  vec_we  = 1'b1;
        mvma_pkg::CMD_LOAD_INIT: init_we = 1'b1;
        mvma_pkg::CMD_MATRIX:    mat_go  = 1'b1;
        default: ;
      endcase
    end
  end

  assign last_col = ({1'b0, col_q} + mvma_pkg::CNT_W'(1)) >= cols_i;
  assign last_row = ({1'b0, row_q} + mvma_pkg::CNT_W'(1)) >= rows_i;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (mat_go) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + mvma_pkg::ADDR_W'(1);
      end else begin
        col_d = col_q + mvma_pkg::ADDR_W'(1);
      end
    end
  end

  mvma_ram #(
    .WIDTH (mvma_pkg::DATA_W),
    .DEPTH (mvma_pkg::STORE_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (index_i),
    .wdata_i (value_i),
    .raddr_i (col_q),
    .rdata_o (vec_rdata)
  );

  mvma_ram #(
    .WIDTH (mvma_pkg::DATA_W),
    .DEPTH (mvma_pkg::STORE_DEPTH)
  ) u_init_ram (
    .clk_i   (clk_i),
    .we_i    (init_we),
    .waddr_i (index_i),
    .wdata_i (value_i),
    .raddr_i (row_q),
    .rdata_o (init_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      init_vld_q <= '0;
      s1_vld_q   <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      s1_vld_q <= mat_go;
      if (init_we) begin
        init_vld_q[index_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_go) begin
      s1_value_q    <= value_i;
      s1_first_q    <= (col_q == '0);
      s1_last_col_q <= last_col;
      s1_row_q      <= row_q;
      s1_last_row_q <= last_row;
      s1_init_ok_q  <= init_vld_q[row_q];
    end
  end

  assign push_o = s1_vld_q;

  always_comb begin
    elem_o.value     = s1_value_q;
    elem_o.vec       = vec_rdata;
    elem_o.init      = s1_init_ok_q ? init_rdata : '0;
    elem_o.first_col = s1_first_q;
    elem_o.last_col  = s1_last_col_q;
    elem_o.row       = s1_row_q;
    elem_o.last_row  = s1_last_row_q;
  end

endmodule

[sv/mvma_fifo.sv]
`timescale 1ns / 1ps

module mvma_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  mvma_pkg::elem_t                 data_i,
  input  logic                            pop_i,
  output logic                            valid_o,
  output mvma_pkg::elem_t                 data_o,
  output logic [mvma_pkg::FIFO_CNT_W-1:0] count_o
);

  mvma_pkg::elem_t                     entry_q [mvma_pkg::FIFO_DEPTH];
  logic [mvma_pkg::FIFO_PTR_W-1:0]     wr_ptr_q;
  logic [mvma_pkg::FIFO_PTR_W-1:0]     rd_ptr_q;
  logic [mvma_pkg::FIFO_CNT_W-1:0]     count_q, count_d;
  logic                                do_pop;

  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + mvma_pkg::FIFO_CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - mvma_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + mvma_pkg::FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + mvma_pkg::FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[sv/mvma_back.sv]
`timescale 1ns / 1ps

module mvma_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         elem_valid_i,
  input  mvma_pkg::elem_t              elem_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mvma_pkg::ADDR_W-1:0]  row_index_o,
  output logic [mvma_pkg::DATA_W-1:0]  row_sum_o,
  output logic                         last_row_o
);

  logic [mvma_pkg::DATA_W-1:0] prod;
  logic [mvma_pkg::DATA_W-1:0] sum;
  logic                        out_free;
  logic                        b1_fire;

  logic                        b1_vld_q;
  logic [mvma_pkg::DATA_W-1:0] b1_prod_q;
  logic [mvma_pkg::DATA_W-1:0] b1_init_q;
  logic                        b1_first_q;
  logic                        b1_last_col_q;
  logic [mvma_pkg::ADDR_W-1:0] b1_row_q;
  logic                        b1_last_row_q;
  logic [mvma_pkg::DATA_W-1:0] acc_q;
  logic                        out_vld_q;
  logic [mvma_pkg::ADDR_W-1:0] out_row_q;
  logic [mvma_pkg::DATA_W-1:0] out_sum_q;
  logic                        out_last_q;

  // low half of the product is the same for signed and unsigned operands
  assign prod = elem_i.value * elem_i.vec;
  assign sum  = (b1_first_q ? b1_init_q : acc_q) + b1_prod_q;

  assign out_free = !out_vld_q || !out_stall_i;
  // only a row-ending element needs the output slot
  assign b1_fire  = b1_vld_q && (!b1_last_col_q || out_free);
  assign pop_o    = elem_valid_i && (!b1_vld_q || b1_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q  <= 1'b0;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        b1_vld_q <= 1'b1;
      end else if (b1_fire) begin
        b1_vld_q <= 1'b0;
      end
      if (b1_fire) begin
        acc_q <= sum;
      end
      if (b1_fire && b1_last_col_q) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_prod_q     <= prod;
      b1_init_q     <= elem_i.init;
      b1_first_q    <= elem_i.first_col;
      b1_last_col_q <= elem_i.last_col;
      b1_row_q      <= elem_i.row;
      b1_last_row_q <= elem_i.last_row;
    end
    if (b1_fire && b1_last_col_q) begin
      out_row_q  <= b1_row_q;
      out_sum_q  <= sum;
      out_last_q <= b1_last_row_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign row_index_o = out_row_q;
  assign row_sum_o   = out_sum_q;
  assign last_row_o  = out_last_q;

endmodule

[sv/matrix_vector_multiply_accumulate.sv]
// Throughput: one item per cycle while in_stall_o is low; loads and matrix elements alike.
// A row's last matrix element reaches the output after acceptance through the read stage,
// queue write, multiply register and accumulate into the output register.
// The 4-entry queue lets the input side keep going while a result waits.
// Reset clears position counters, accumulator, initial-sum valid bits and both
// counts to 1; the vector store stays undefined until written.
`timescale 1ns / 1ps

module matrix_vector_multiply_accumulate (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         command_i,
  input  logic [mvma_pkg::ADDR_W-1:0]        index_i,
  input  logic signed [mvma_pkg::DATA_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mvma_pkg::ADDR_W-1:0]        row_index_o,
  output logic signed [mvma_pkg::DATA_W-1:0] row_sum_o,
  output logic                               last_row_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [mvma_pkg::CNT_W-1:0]      row_count_q;
  logic [mvma_pkg::CNT_W-1:0]      col_count_q;
  logic [mvma_pkg::CNT_W-1:0]      rows;
  logic [mvma_pkg::CNT_W-1:0]      cols;
  logic                            cfg_wr;
  logic                            push;
  mvma_pkg::elem_t                 push_elem;
  logic                            pop;
  logic                            fifo_vld;
  mvma_pkg::elem_t                 fifo_elem;
  logic [mvma_pkg::FIFO_CNT_W-1:0] fifo_count;
  logic [mvma_pkg::DATA_W-1:0]     row_sum;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= mvma_pkg::CNT_W'(1);
      col_count_q <= mvma_pkg::CNT_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == mvma_pkg::REG_ROW_COUNT) begin
        row_count_q <= pwdata[mvma_pkg::CNT_W-1:0];
      end else begin
        col_count_q <= pwdata[mvma_pkg::CNT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == mvma_pkg::REG_COL_COUNT) ?
                  {{(32-mvma_pkg::CNT_W){1'b0}}, col_count_q} :
                  {{(32-mvma_pkg::CNT_W){1'b0}}, row_count_q};

  assign rows = mvma_pkg::eff_count(row_count_q);
  assign cols = mvma_pkg::eff_count(col_count_q);

  mvma_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .rows_i       (rows),
    .cols_i       (cols),
    .fifo_count_i (fifo_count),
    .push_o       (push),
    .elem_o       (push_elem)
  );

  mvma_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_elem),
    .pop_i   (pop),
    .valid_o (fifo_vld),
    .data_o  (fifo_elem),
    .count_o (fifo_count)
  );

  mvma_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .elem_valid_i (fifo_vld),
    .elem_i       (fifo_elem),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_index_o  (row_index_o),
    .row_sum_o    (row_sum),
    .last_row_o   (last_row_o)
  );

  assign row_sum_o = row_sum;

endmodule

[sv/mvma_checker.sv]
`timescale 1ns / 1ps

module mvma_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  index_i,
  input  logic [31:0] value_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [7:0]  row_index_o,
  input  logic [31:0] row_sum_o,
  input  logic        last_row_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(row_index_o)
      && $stable(row_sum_o) && $stable(last_row_o))
    else $error("stalled result changed");

  // row 255 can only be the final row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_index_o == 8'd255 |-> last_row_o)
    else $error("row 255 not flagged as last row");

  // a written row count reads back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && !paddr[2] |=>
      paddr[2] || prdata == {23'b0, $past(pwdata[8:0])})
    else $error("row_count readback mismatch");

  // a written column count reads back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2] |=>
      !paddr[2] || prdata == {23'b0, $past(pwdata[8:0])})
    else $error("col_count readback mismatch");

endmodule

bind matrix_vector_multiply_accumulate mvma_checker u_mvma_checker (.*);

[bench/mvma_row_checker.sv]
`timescale 1ns / 1ps

module mvma_row_checker
  import mvma_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [1:0]               command_i,
  input  logic [ADDR_W-1:0]        index_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [ADDR_W-1:0]        row_index_i,
  input  logic signed [DATA_W-1:0] row_sum_i,
  input  logic                     last_row_i,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic                     pready_i,
  input  logic [2:0]               paddr_i,
  input  logic [31:0]              pwdata_i,
  output int unsigned              fail_count_o,
  output int unsigned              rows_due_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] row;
    logic [DATA_W-1:0] sum;
    logic              last;
  } row_result_t;

  row_result_t       rows_due[$];
  row_result_t       due_row;
  logic [DATA_W-1:0] vec_mem  [STORE_DEPTH];
  logic [DATA_W-1:0] init_mem [STORE_DEPTH];
  logic [DATA_W-1:0] acc;
  int unsigned       row_pos;
  int unsigned       col_pos;
  logic [CNT_W-1:0]  row_reg;
  logic [CNT_W-1:0]  col_reg;

  // zero means one, anything past the store depth saturates
  function automatic int unsigned span_of(input logic [CNT_W-1:0] r);
    if (r == '0) return 1;
    if (r > CNT_W'(STORE_DEPTH)) return STORE_DEPTH;
    return r;
  endfunction

  // a position at or past the limit counts as the last one
  function automatic void accumulate_element(input logic [DATA_W-1:0] elem);
    logic [DATA_W-1:0] base;
    row_result_t       res;
    base = (col_pos == 0) ? init_mem[row_pos] : acc;
    acc  = base + elem * vec_mem[col_pos];
    if (col_pos + 1 >= span_of(col_reg)) begin
      res.row  = ADDR_W'(row_pos);
      res.sum  = acc;
      res.last = (row_pos + 1 >= span_of(row_reg));
      rows_due.push_back(res);
      col_pos = 0;
      row_pos = res.last ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_due.delete();
      foreach (vec_mem[i]) begin
        vec_mem[i]  = '0;
        init_mem[i] = '0;
      end
      acc          = '0;
      row_pos      = 0;
      col_pos      = 0;
      row_reg      = CNT_W'(1);
      col_reg      = CNT_W'(1);
      fail_count_o = 0;
      rows_due_o   = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_ROW_COUNT) begin
          row_reg = pwdata_i[CNT_W-1:0];
        end else begin
          col_reg = pwdata_i[CNT_W-1:0];
        end
      end

      if (in_valid_i && !in_stall_i) begin
        case (command_i)
          CMD_LOAD_VEC:  vec_mem[index_i]  = value_i;
          CMD_LOAD_INIT: init_mem[index_i] = value_i;
          CMD_MATRIX:    accumulate_element(value_i);
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (rows_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT) begin
            $display("%0t: unexpected row result: row %0d sum %0d last %0b", $realtime,
                     row_index_i, row_sum_i, last_row_i);
          end
        end else begin
          due_row = rows_due.pop_front();
          if (due_row.row !== row_index_i || due_row.sum !== row_sum_i ||
              due_row.last !== last_row_i) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT) begin
              $display("%0t: row result mismatch: expected row %0d sum %0d last %0b, got row %0d sum %0d last %0b",
                       $realtime, due_row.row, $signed(due_row.sum), due_row.last,
                       row_index_i, row_sum_i, last_row_i);
            end
          end
        end
      end

      rows_due_o = rows_due.size();
    end
  end

endmodule

[bench/tb_matrix_vector_multiply_accumulate.sv]
`timescale 1ns / 1ps

module tb_matrix_vector_multiply_accumulate;
  import mvma_pkg::*;

  typedef enum logic [1:0] {
    GAP_NONE,
    GAP_SENDER,
    GAP_RECEIVER,
    GAP_BOTH
  } gap_mode_e;

  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int          PHASES       = 6;
  localparam int          PAUSE_PHASE  = 5;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 80;

  localparam logic [CNT_W-1:0] ROW_SETTINGS [PHASES] = '{3, 2, 0, 511, 6, 4};
  localparam logic [CNT_W-1:0] COL_SETTINGS [PHASES] = '{4, 511, 0, 1, 3, 7};
  localparam int unsigned      PHASE_ITEMS  [PHASES] = '{160, 420, 60, 380, 160, 150};
  localparam gap_mode_e        PHASE_GAPS   [PHASES] =
    '{GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH, GAP_RECEIVER, GAP_SENDER};

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               command_i;
  logic [ADDR_W-1:0]        index_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [ADDR_W-1:0]        row_index_o;
  logic signed [DATA_W-1:0] row_sum_o;
  logic                     last_row_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [2:0]               paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  int unsigned fail_count;
  int unsigned rows_due;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  logic        hold_armed   = 1'b0;
  logic        hold_done    = 1'b0;
  int unsigned hold_left    = 0;
  logic        vec_loaded [STORE_DEPTH];
  int unsigned next_col;
  int unsigned col_lim;
  int unsigned row_lim;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  matrix_vector_multiply_accumulate DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_index_o (row_index_o),
    .row_sum_o   (row_sum_o),
    .last_row_o  (last_row_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  mvma_row_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .command_i    (command_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_index_i  (row_index_o),
    .row_sum_i    (row_sum_o),
    .last_row_i   (last_row_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .rows_due_o   (rows_due)
  );

  // one long hold once armed, random stalls otherwise
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES - 1;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic int unsigned in_use(input logic [CNT_W-1:0] r);
    if (r == '0) return 1;
    if (r > CNT_W'(STORE_DEPTH)) return STORE_DEPTH;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return '1;
          default: return '0;
        endcase
      end
      1: return DATA_W'($urandom_range(16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_index(input int unsigned lim);
    if ($urandom_range(1) == 0) return ADDR_W'($urandom_range(lim - 1));
    return ADDR_W'($urandom);
  endfunction

  function automatic void set_gaps(input gap_mode_e mode);
    case (mode)
      GAP_SENDER: begin
        send_gap_pct = 55;
        stall_pct    = 0;
      end
      GAP_RECEIVER: begin
        send_gap_pct = 0;
        stall_pct    = 55;
      end
      GAP_BOTH: begin
        send_gap_pct = 10;
        stall_pct    = 10;
      end
      default: begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
    endcase
  endfunction

  // offer one item and hold it until it is taken
  task automatic send_item(input logic [1:0] cmd, input logic [ADDR_W-1:0] idx,
                           input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    index_i    <= idx;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (cmd == CMD_LOAD_VEC) begin
      vec_loaded[idx] = 1'b1;
    end else if (cmd == CMD_MATRIX) begin
      next_col = (next_col + 1 >= col_lim) ? 0 : next_col + 1;
    end
  endtask

  // mostly matrix elements; never let a matrix element read an unloaded vector entry
  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      if (!vec_loaded[next_col]) send_item(CMD_LOAD_VEC, ADDR_W'(next_col), pick_word());
      send_item(CMD_MATRIX, ADDR_W'($urandom), pick_word());
    end else if (pick < 82) begin
      send_item(CMD_LOAD_VEC, pick_index(col_lim), pick_word());
    end else if (pick < 94) begin
      send_item(CMD_LOAD_INIT, pick_index(row_lim), pick_word());
    end else begin
      send_item(CMD_UNUSED, ADDR_W'($urandom), pick_word());
    end
  endtask

  task automatic write_reg(input logic reg_sel, input logic [CNT_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid, wait out every pending row, then let loads in flight land
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rows_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    in_valid_i = 1'b0;
    command_i  = CMD_LOAD_VEC;
    index_i    = '0;
    value_i    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    next_col   = 0;
    col_lim    = 1;
    row_lim    = 1;
    foreach (vec_loaded[i]) vec_loaded[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-by-one matrix at reset counts: field extremes, ignored index,
    // unused command, loads past the count, initial sum reused every time
    send_item(CMD_LOAD_VEC,  8'h00, 32'h7FFF_FFFF);
    send_item(CMD_LOAD_VEC,  8'hFF, 32'h8000_0000);
    send_item(CMD_LOAD_INIT, 8'h00, 32'h8000_0000);
    send_item(CMD_LOAD_INIT, 8'hFF, 32'hFFFF_FFFF);
    send_item(CMD_MATRIX,    8'hFF, 32'hFFFF_FFFF);
    send_item(CMD_MATRIX,    8'h00, 32'h8000_0000);
    send_item(CMD_MATRIX,    8'hAA, 32'h7FFF_FFFF);
    send_item(CMD_MATRIX,    8'h55, 32'h0000_0000);
    send_item(CMD_UNUSED,    8'hAA, 32'h5555_5555);
    send_item(CMD_UNUSED,    8'h55, 32'hAAAA_AAAA);
    send_item(CMD_MATRIX,    8'h00, 32'h0000_0001);
    send_item(CMD_LOAD_VEC,  8'h00, 32'hFFFF_FFFF);
    send_item(CMD_MATRIX,    8'h00, 32'hFFFF_FFFF);
    send_item(CMD_MATRIX,    8'h00, 32'h8000_0000);
    send_item(CMD_LOAD_INIT, 8'h00, 32'h7FFF_FFFF);
    send_item(CMD_MATRIX,    8'h00, 32'h7FFF_FFFF);
    send_item(CMD_MATRIX,    8'h00, 32'h0000_0001);
    send_item(CMD_LOAD_VEC,  8'hAA, 32'h1234_5678);
    send_item(CMD_LOAD_INIT, 8'h55, 32'hAAAA_AAAA);
    send_item(CMD_LOAD_INIT, 8'hAA, 32'h5555_5555);
    send_item(CMD_LOAD_VEC,  8'h00, 32'h5555_5555);
    send_item(CMD_MATRIX,    8'h55, 32'hAAAA_AAAA);
    send_item(CMD_MATRIX,    8'hFF, 32'h5555_5555);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(REG_ROW_COUNT, ROW_SETTINGS[p]);
      write_reg(REG_COL_COUNT, COL_SETTINGS[p]);
      row_lim = in_use(ROW_SETTINGS[p]);
      col_lim = in_use(COL_SETTINGS[p]);
      set_gaps(PHASE_GAPS[p]);
      // first phase runs the sender flat out into a long receiver hold
      if (p == 0) hold_armed <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        if (p == PAUSE_PHASE && n == PHASE_ITEMS[p] / 2) settle();
        send_random_item();
      end
    end

    settle();
    if (fail_count == 0 && rows_due == 0) begin
      $display("[matrix_vector_multiply_accumulate] OK");
    end else begin
      $display("[matrix_vector_multiply_accumulate] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[matrix_vector_multiply_accumulate] ERROR");
    $finish;
  end

endmodule
